// ===== rtl/eatbv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eatbv_pkg
// Shared constants and arithmetic helpers for the Euler-angle basis pipeline.
// ----------------------------------------------------------------------------
package eatbv_pkg;

   localparam int ANGLE_FRAC_BITS = 6;
   localparam int OUT_FRAC_BITS   = 15;

   localparam int Q30 = 30;
   localparam logic [31:0] PI_OVER_180_Q30 = 32'd18740330;
   localparam logic [31:0] Q30_ONE = 32'h4000_0000;

   // Reciprocals for the series divisors: m = ceil(2^k / d), k = 30 + ceil(log2 d).
   // Exact floor(n / d) for every n below 2^30.
   localparam int SH_72 = 37;
   localparam int SH_42 = 36;
   localparam int SH_20 = 35;
   localparam int SH_6  = 33;
   localparam int SH_90 = 37;
   localparam int SH_56 = 36;
   localparam int SH_30 = 35;
   localparam int SH_12 = 34;
   localparam logic [31:0] RCP_72 = 32'(((64'd1 << SH_72) + 64'd71) / 64'd72);
   localparam logic [31:0] RCP_42 = 32'(((64'd1 << SH_42) + 64'd41) / 64'd42);
   localparam logic [31:0] RCP_20 = 32'(((64'd1 << SH_20) + 64'd19) / 64'd20);
   localparam logic [31:0] RCP_6  = 32'(((64'd1 << SH_6) + 64'd5) / 64'd6);
   localparam logic [31:0] RCP_90 = 32'(((64'd1 << SH_90) + 64'd89) / 64'd90);
   localparam logic [31:0] RCP_56 = 32'(((64'd1 << SH_56) + 64'd55) / 64'd56);
   localparam logic [31:0] RCP_30 = 32'(((64'd1 << SH_30) + 64'd29) / 64'd30);
   localparam logic [31:0] RCP_12 = 32'(((64'd1 << SH_12) + 64'd11) / 64'd12);

   // Signed Q2.30 value: one sign bit, 33 bits in all
   typedef logic signed [32:0] q30_type;

   typedef struct packed {
      q30_type sn;
      q30_type cs;
   } sc_type;

   // floor(a*b / 2^30) for non-negative Q2.30 operands
   function automatic logic [31:0] umul30(input logic [31:0] a, input logic [31:0] b);
      logic [63:0] p;
      begin
         p = a * b;
         umul30 = p[61:30];
      end
   endfunction

   // floor(n / d) by reciprocal multiply, m and k from the table above
   function automatic logic [31:0] div_rcp(input logic [31:0] n, input logic [31:0] m,
                                           input int k);
      logic [63:0] p;
      begin
         p = n * m;
         div_rcp = 32'(p >> k);
      end
   endfunction

   // Q2.30 product rounded half away from zero
   function automatic q30_type qmul(input q30_type a, input q30_type b);
      logic        neg;
      logic [31:0] ua;
      logic [31:0] ub;
      logic [63:0] p;
      logic [33:0] r;
      begin
         neg = a[32] ^ b[32];
         ua  = a[32] ? 32'(-a) : a[31:0];
         ub  = b[32] ? 32'(-b) : b[31:0];
         p   = ua * ub + 64'(1) * (64'd1 << 29);
         r   = {1'b0, p[62:30]};
         qmul = neg ? -q30_type'(r) : q30_type'(r);
      end
   endfunction

endpackage

// ===== rtl/eatbv_sincos.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eatbv_sincos
// Pipelined sine/cosine of one angle: reduction, radians, Horner series,
// quadrant map. Advances on en.
// ----------------------------------------------------------------------------
module eatbv_sincos #(
   parameter int ANGLE_FRAC_BITS = eatbv_pkg::ANGLE_FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [15:0]   angle,
   output eatbv_pkg::sc_type    sc
);
   localparam int FULL    = 360 << ANGLE_FRAC_BITS;
   localparam int QUARTER = 90 << ANGLE_FRAC_BITS;
   localparam int TW      = $clog2(FULL + 1);
   localparam int NS      = 12;

   // reduction: bias to non-negative by a multiple of a full turn, then
   // quotient by reciprocal multiply (exact for every biased value)
   localparam int OFF = FULL * ((32768 + FULL - 1) / FULL);
   localparam int UW  = $clog2(32768 + OFF);
   localparam int FL  = $clog2(FULL);
   localparam int RK  = UW + FL;
   localparam logic [63:0] RM = ((64'd1 << RK) + 64'(FULL) - 64'd1) / 64'(FULL);

   // per-stage payload
   logic [1:0]  q_ff   [NS];
   logic        sw_ff  [NS];
   logic [31:0] x_ff   [NS];
   logic [31:0] x2_ff  [NS];
   logic [31:0] s_ff   [NS];
   logic [31:0] c_ff   [NS];

   // reduction mod 360 degrees
   logic [UW-1:0] u;
   logic [63:0]   uq;
   logic [63:0]   rr;
   logic [TW-1:0] red_ff;
   always_comb begin
      u  = UW'(32'(angle) + OFF);
      uq = (64'(u) * RM) >> RK;
      rr = 64'(u) - uq * 64'(FULL);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         red_ff <= TW'(rr);
      end
   end

   // stage 0: quadrant split
   logic signed [31:0] r;
   logic [TW-1:0]      t;
   logic [1:0]         q;
   logic [TW-1:0]      tt;
   logic               sw;
   logic [31:0]        t_in;
   always_comb begin
      r = 32'(red_ff);
      if (r >= 3 * QUARTER) begin
         q = 2'd3; t = TW'(r - 3 * QUARTER);
      end else if (r >= 2 * QUARTER) begin
         q = 2'd2; t = TW'(r - 2 * QUARTER);
      end else if (r >= QUARTER) begin
         q = 2'd1; t = TW'(r - QUARTER);
      end else begin
         q = 2'd0; t = TW'(r);
      end
      sw = ({1'b0, t} << 1) > (TW+1)'(QUARTER);
      tt = sw ? TW'(QUARTER) - t : t;
      t_in = 32'(tt);
   end

   logic [63:0] xp;
   logic [63:0] xr;
   logic [63:0] xx;
   always_comb begin
      xp = 64'(x_ff[0]) * 64'(eatbv_pkg::PI_OVER_180_Q30);
      if (ANGLE_FRAC_BITS > 0)
         xr = (xp + (64'd1 << (ANGLE_FRAC_BITS > 0 ? ANGLE_FRAC_BITS - 1 : 0)))
              >> ANGLE_FRAC_BITS;
      else
         xr = xp;
      xx = 64'(x_ff[1]) * 64'(x_ff[1]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // 0: reduced angle
         q_ff[0] <= q; sw_ff[0] <= sw; x_ff[0] <= t_in;
         x2_ff[0] <= '0; s_ff[0] <= '0; c_ff[0] <= '0;
         // 1: radians
         q_ff[1] <= q_ff[0]; sw_ff[1] <= sw_ff[0]; x_ff[1] <= xr[31:0];
         x2_ff[1] <= '0; s_ff[1] <= '0; c_ff[1] <= '0;
         // 2: square
         q_ff[2] <= q_ff[1]; sw_ff[2] <= sw_ff[1]; x_ff[2] <= x_ff[1];
         x2_ff[2] <= xx[61:30]; s_ff[2] <= '0; c_ff[2] <= '0;
         // 3: first Horner terms
         q_ff[3] <= q_ff[2]; sw_ff[3] <= sw_ff[2]; x_ff[3] <= x_ff[2];
         x2_ff[3] <= x2_ff[2];
         s_ff[3] <= eatbv_pkg::Q30_ONE
                    - eatbv_pkg::div_rcp(x2_ff[2], eatbv_pkg::RCP_72, eatbv_pkg::SH_72);
         c_ff[3] <= eatbv_pkg::Q30_ONE
                    - eatbv_pkg::div_rcp(x2_ff[2], eatbv_pkg::RCP_90, eatbv_pkg::SH_90);
         // 4: product, 5: divide-subtract (pairs)
         q_ff[4] <= q_ff[3]; sw_ff[4] <= sw_ff[3]; x_ff[4] <= x_ff[3];
         x2_ff[4] <= x2_ff[3];
         s_ff[4] <= eatbv_pkg::umul30(x2_ff[3], s_ff[3]);
         c_ff[4] <= eatbv_pkg::umul30(x2_ff[3], c_ff[3]);
         q_ff[5] <= q_ff[4]; sw_ff[5] <= sw_ff[4]; x_ff[5] <= x_ff[4];
         x2_ff[5] <= x2_ff[4];
         s_ff[5] <= eatbv_pkg::Q30_ONE
                    - eatbv_pkg::div_rcp(s_ff[4], eatbv_pkg::RCP_42, eatbv_pkg::SH_42);
         c_ff[5] <= eatbv_pkg::Q30_ONE
                    - eatbv_pkg::div_rcp(c_ff[4], eatbv_pkg::RCP_56, eatbv_pkg::SH_56);
         q_ff[6] <= q_ff[5]; sw_ff[6] <= sw_ff[5]; x_ff[6] <= x_ff[5];
         x2_ff[6] <= x2_ff[5];
         s_ff[6] <= eatbv_pkg::umul30(x2_ff[5], s_ff[5]);
         c_ff[6] <= eatbv_pkg::umul30(x2_ff[5], c_ff[5]);
         q_ff[7] <= q_ff[6]; sw_ff[7] <= sw_ff[6]; x_ff[7] <= x_ff[6];
         x2_ff[7] <= x2_ff[6];
         s_ff[7] <= eatbv_pkg::Q30_ONE
                    - eatbv_pkg::div_rcp(s_ff[6], eatbv_pkg::RCP_20, eatbv_pkg::SH_20);
         c_ff[7] <= eatbv_pkg::Q30_ONE
                    - eatbv_pkg::div_rcp(c_ff[6], eatbv_pkg::RCP_30, eatbv_pkg::SH_30);
         q_ff[8] <= q_ff[7]; sw_ff[8] <= sw_ff[7]; x_ff[8] <= x_ff[7];
         x2_ff[8] <= x2_ff[7];
         s_ff[8] <= eatbv_pkg::umul30(x2_ff[7], s_ff[7]);
         c_ff[8] <= eatbv_pkg::umul30(x2_ff[7], c_ff[7]);
         q_ff[9] <= q_ff[8]; sw_ff[9] <= sw_ff[8]; x_ff[9] <= x_ff[8];
         x2_ff[9] <= x2_ff[8];
         s_ff[9] <= eatbv_pkg::Q30_ONE
                    - eatbv_pkg::div_rcp(s_ff[8], eatbv_pkg::RCP_6, eatbv_pkg::SH_6);
         c_ff[9] <= eatbv_pkg::Q30_ONE
                    - eatbv_pkg::div_rcp(c_ff[8], eatbv_pkg::RCP_12, eatbv_pkg::SH_12);
         q_ff[10] <= q_ff[9]; sw_ff[10] <= sw_ff[9]; x_ff[10] <= x_ff[9];
         x2_ff[10] <= x2_ff[9];
         s_ff[10] <= eatbv_pkg::umul30(x_ff[9], s_ff[9]);
         c_ff[10] <= eatbv_pkg::umul30(x2_ff[9], c_ff[9]);
         q_ff[11] <= q_ff[10]; sw_ff[11] <= sw_ff[10]; x_ff[11] <= x_ff[10];
         x2_ff[11] <= x2_ff[10];
         s_ff[11] <= s_ff[10];
         c_ff[11] <= eatbv_pkg::Q30_ONE - (c_ff[10] >> 1);
      end
   end

   // quadrant map
   eatbv_pkg::q30_type s;
   eatbv_pkg::q30_type c;
   always_comb begin
      s = sw_ff[NS-1] ? {1'b0, c_ff[NS-1]} : {1'b0, s_ff[NS-1]};
      c = sw_ff[NS-1] ? {1'b0, s_ff[NS-1]} : {1'b0, c_ff[NS-1]};
      case (q_ff[NS-1])
         2'd0: begin sc.sn = s;  sc.cs = c;  end
         2'd1: begin sc.sn = c;  sc.cs = -s; end
         2'd2: begin sc.sn = -s; sc.cs = -c; end
         default: begin sc.sn = -c; sc.cs = s; end
      endcase
   end
endmodule

// ===== rtl/eatbv_combine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eatbv_combine
// Products and sums of the basis vectors, rounding and saturation to the
// output format. Three register stages, advances on en.
// ----------------------------------------------------------------------------
module eatbv_combine #(
   parameter int OUT_FRAC_BITS = eatbv_pkg::OUT_FRAC_BITS
) (
   input  logic               clock,
   input  logic               en,
   input  eatbv_pkg::sc_type  pit,
   input  eatbv_pkg::sc_type  yaw,
   input  eatbv_pkg::sc_type  rol,
   output logic [15:0]        res [9]
);
   localparam int SH = 30 - OUT_FRAC_BITS;

   typedef logic signed [34:0] acc_type;

   function automatic logic [15:0] to_out(input acc_type v);
      logic        neg;
      logic [34:0] m;
      logic signed [36:0] r;
      begin
         neg = v[34];
         m   = neg ? 35'(-v) : 35'(v);
         if (SH > 0)
            m = (m + (35'd1 << (SH > 0 ? SH - 1 : 0))) >> (SH > 0 ? SH : 0);
         if (m > (35'd1 << 20)) m = 35'd1 << 20;
         r = neg ? -37'(m) : 37'(m);
         if (r > 37'sd32767) r = 37'sd32767;
         if (r < -37'sd32768) r = -37'sd32768;
         to_out = r[15:0];
      end
   endfunction

   eatbv_pkg::q30_type sp_ff, cp_ff, sy_ff, cy_ff, sr_ff, cr_ff;
   eatbv_pkg::q30_type srsp_ff, crsp_ff;
   eatbv_pkg::q30_type sy2_ff, cy2_ff, sr2_ff, cr2_ff;
   acc_type            v_ff [9];

   always_ff @(posedge clock) begin
      if (en) begin
         sp_ff <= pit.sn; cp_ff <= pit.cs; sy_ff <= yaw.sn; cy_ff <= yaw.cs;
         sr_ff <= rol.sn; cr_ff <= rol.cs;
         // first product tier
         srsp_ff <= eatbv_pkg::qmul(sr_ff, sp_ff);
         crsp_ff <= eatbv_pkg::qmul(cr_ff, sp_ff);
         sy2_ff <= sy_ff; cy2_ff <= cy_ff; sr2_ff <= sr_ff; cr2_ff <= cr_ff;
         v_ff[0] <= acc_type'(eatbv_pkg::qmul(cp_ff, cy_ff));
         v_ff[1] <= acc_type'(eatbv_pkg::qmul(cp_ff, sy_ff));
         v_ff[2] <= -acc_type'(sp_ff);
         v_ff[5] <= -acc_type'(eatbv_pkg::qmul(sr_ff, cp_ff));
         v_ff[8] <= acc_type'(eatbv_pkg::qmul(cr_ff, cp_ff));
         // second tier
         v_ff[3] <= -acc_type'(eatbv_pkg::qmul(srsp_ff, cy2_ff))
                    + acc_type'(eatbv_pkg::qmul(cr2_ff, sy2_ff));
         v_ff[4] <= -acc_type'(eatbv_pkg::qmul(srsp_ff, sy2_ff))
                    - acc_type'(eatbv_pkg::qmul(cr2_ff, cy2_ff));
         v_ff[6] <= acc_type'(eatbv_pkg::qmul(crsp_ff, cy2_ff))
                    + acc_type'(eatbv_pkg::qmul(sr2_ff, sy2_ff));
         v_ff[7] <= acc_type'(eatbv_pkg::qmul(crsp_ff, sy2_ff))
                    - acc_type'(eatbv_pkg::qmul(sr2_ff, cy2_ff));
      end
   end

   // single-tier terms pass through d_ff to line up with the second tier
   acc_type d_ff [9];
   always_ff @(posedge clock) begin
      if (en) begin
         d_ff <= v_ff;
      end
   end

   always_comb begin
      res[0] = to_out(d_ff[0]);
      res[1] = to_out(d_ff[1]);
      res[2] = to_out(d_ff[2]);
      res[3] = to_out(v_ff[3]);
      res[4] = to_out(v_ff[4]);
      res[5] = to_out(d_ff[5]);
      res[6] = to_out(v_ff[6]);
      res[7] = to_out(v_ff[7]);
      res[8] = to_out(d_ff[8]);
   end
endmodule

// ===== rtl/euler_angles_to_basis_vectors.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_angles_to_basis_vectors
// Converts pitch/yaw/roll into forward, right and up unit vectors (Q1.15).
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one word of three angles (degrees * 64, signed).
//   rsp_ channel returns one word of nine saturated Q1.15 components.
//   Throughput: one word per cycle while the receiver does not stall.
//   The pipeline has 16 register stages, set by the 13-stage sine/cosine
//   pipeline (reduction, quadrant split, radians, series) and the 3-stage
//   product/round pipeline.
//   The pipeline advances as a whole when the output stage is empty or
//   being taken; a stalled receiver freezes every stage, so no word is
//   dropped or repeated, and req_ready falls with it.
//   Synchronous reset clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
module euler_angles_to_basis_vectors #(
   parameter int ANGLE_FRAC_BITS = eatbv_pkg::ANGLE_FRAC_BITS,
   parameter int OUT_FRAC_BITS   = eatbv_pkg::OUT_FRAC_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_pitch_deg,
   input  logic signed [15:0] req_yaw_deg,
   input  logic signed [15:0] req_roll_deg,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_fwd_x,
   output logic signed [15:0] rsp_fwd_y,
   output logic signed [15:0] rsp_fwd_z,
   output logic signed [15:0] rsp_rgt_x,
   output logic signed [15:0] rsp_rgt_y,
   output logic signed [15:0] rsp_rgt_z,
   output logic signed [15:0] rsp_upv_x,
   output logic signed [15:0] rsp_upv_y,
   output logic signed [15:0] rsp_upv_z
);
   localparam int LAT = 16;

   // global enable: whole pipe moves when the last stage can drain
   logic en;
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;
   assign en        = !vld_ff[LAT-1] || rsp_ready;
   assign req_ready = en;
   assign vld_in    = {vld_ff[LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   eatbv_pkg::sc_type sc_p, sc_y, sc_r;

   eatbv_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_p (
      .clock(clock), .en(en), .angle(req_pitch_deg), .sc(sc_p));
   eatbv_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_y (
      .clock(clock), .en(en), .angle(req_yaw_deg), .sc(sc_y));
   eatbv_sincos #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_sc_r (
      .clock(clock), .en(en), .angle(req_roll_deg), .sc(sc_r));

   logic [15:0] res [9];
   eatbv_combine #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_comb (
      .clock(clock), .en(en), .pit(sc_p), .yaw(sc_y), .rol(sc_r), .res(res));

   assign rsp_valid = vld_ff[LAT-1];
   assign rsp_fwd_x = res[0];
   assign rsp_fwd_y = res[1];
   assign rsp_fwd_z = res[2];
   assign rsp_rgt_x = res[3];
   assign rsp_rgt_y = res[4];
   assign rsp_rgt_z = res[5];
   assign rsp_upv_x = res[6];
   assign rsp_upv_y = res[7];
   assign rsp_upv_z = res[8];
endmodule

// ===== rtl/eatbv_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eatbv_checker
// Port-level checks of the basis-vector pipeline.
// ----------------------------------------------------------------------------
module eatbv_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("rsp_valid after reset");
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("not ready with empty output");
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready) else $error("accept while stalled");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("rsp dropped");
endmodule

bind euler_angles_to_basis_vectors eatbv_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready));
